### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the find/replace core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SFR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// checked at every edge, reset included
`define SFR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

### design/sfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Types, constants and helpers of the stream find/replace core.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned PatternMax = 8;
  localparam int unsigned ReplMax    = 8;
  localparam int unsigned WordBytes  = 8;

  localparam int unsigned CntW  = $clog2(PatternMax + 1);
  localparam int unsigned RlenW = $clog2(ReplMax + 1);
  localparam int unsigned RidxW = (ReplMax > 1) ? $clog2(ReplMax) : 1;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgPatBytes = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPatLen   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepBytes = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgRepLen   = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StRepl,
    StFlush,
    StDone
  } state_e;

  typedef struct packed {
    logic            load;
    logic            shift;
    logic [7:0]      din;
    logic [CntW-1:0] count;
    logic [CntW-1:0] plen;
  } chain_ctl_t;

  typedef struct packed {
    logic       is_prefix;
    logic [7:0] head;
  } chain_st_t;

  function automatic logic [7:0] byte_at(logic [63:0] word, int unsigned idx);
    logic [63:0] sh;
    sh = word >> (idx * 8);
    if (idx >= WordBytes) return 8'h00;
    return sh[7:0];
  endfunction

  function automatic int unsigned clamp_len(logic [3:0] len, int unsigned maxv);
    if (32'(len) > maxv) return maxv;
    return 32'(len);
  endfunction

endpackage

### design/sfr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_cell
// One pending byte slot: loads a new byte, shifts from its neighbor, and
// compares its byte against its pattern byte.
// ----------------------------------------------------------------------------
module sfr_cell (
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       shift_i,
  input  logic [7:0] din_i,
  input  logic [7:0] next_i,
  input  logic [7:0] pat_i,
  output logic [7:0] byte_o,
  output logic       match_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= din_i;
    end else if (shift_i) begin
      byte_q <= next_i;
    end
  end

  assign byte_o  = byte_q;
  assign match_o = (byte_q == pat_i);

endmodule

### design/sfr_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_chain
// Row of pending byte cells with pattern prefix detection.
// ----------------------------------------------------------------------------
module sfr_chain (
  input  logic                clk_i,
  input  sfr_pkg::chain_ctl_t ctl_i,
  input  logic [63:0]         pattern_i,
  output sfr_pkg::chain_st_t  st_o
);

  logic [7:0] bytes [sfr_pkg::PatternMax];
  logic [sfr_pkg::PatternMax-1:0] ok;

  for (genvar i = 0; i < int'(sfr_pkg::PatternMax); i++) begin : g_cell
    logic [7:0] next_byte;
    logic       match;

    if (i == int'(sfr_pkg::PatternMax) - 1) begin : g_tail
      assign next_byte = 8'h00;
    end else begin : g_mid
      assign next_byte = bytes[i+1];
    end

    sfr_cell u_cell (
      .clk_i   (clk_i),
      .load_i  (ctl_i.load && (ctl_i.count == sfr_pkg::CntW'(i))),
      .shift_i (ctl_i.shift),
      .din_i   (ctl_i.din),
      .next_i  (next_byte),
      .pat_i   (sfr_pkg::byte_at(pattern_i, i)),
      .byte_o  (bytes[i]),
      .match_o (match)
    );

    // slots at or above the fill count do not take part
    assign ok[i] = match || (sfr_pkg::CntW'(i) >= ctl_i.count);
  end

  assign st_o.is_prefix = (ctl_i.count <= ctl_i.plen) && (&ok);
  assign st_o.head      = bytes[0];

endmodule

### design/stream_find_replace_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_replace_core
// Streaming find-and-replace over a byte string with end mark.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid_i/in_ready_o, data_byte_i,        | in
//          | end_of_string_i                           |
//  out     | out_valid_o/out_ready_i, out_byte_o,       | out
//          | byte_valid_o, final_item_o                |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i,      | in
//          | cfg_data_i                                |
//
// One input beat at a time (in_ready_o only while idle): the sequencer shifts
// out non-prefix bytes, emits the replacement on a full match, and flushes
// pending bytes when the end mark arrives without a completed match (flush pass).
// Output stalls hold the sequencer; the output register frees the next beat.
// rst_ni clears control state asynchronously; cfg writes are taken each cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stream_find_replace_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         end_of_string_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   out_byte_o,
  output logic                         byte_valid_o,
  output logic                         final_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [63:0]                  cfg_data_i
);

  logic [63:0] pat_bytes_q, rep_bytes_q;
  logic [3:0]  pat_len_q, rep_len_q;

  sfr_pkg::state_e state_q, state_d;
  logic [sfr_pkg::CntW-1:0]  cnt_q, cnt_d, plen;
  logic [sfr_pkg::RidxW-1:0] ridx_q, ridx_d;
  logic [sfr_pkg::RlenW-1:0] rlen;
  logic last_q, last_d;

  logic       hold_valid_q;
  logic [7:0] hold_byte_q;
  logic       out_valid_q, out_bvalid_q, out_final_q;
  logic [7:0] out_byte_q;

  logic       slot_free, can_prod, prod, emit_end;
  logic [7:0] prod_byte;

  sfr_pkg::chain_ctl_t ctl;
  sfr_pkg::chain_st_t  st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= '0;
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sfr_pkg::CfgPatBytes: pat_bytes_q <= cfg_data_i;
        sfr_pkg::CfgPatLen:   pat_len_q   <= cfg_data_i[3:0];
        sfr_pkg::CfgRepBytes: rep_bytes_q <= cfg_data_i;
        sfr_pkg::CfgRepLen:   rep_len_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign plen = sfr_pkg::CntW'(sfr_pkg::clamp_len(pat_len_q, sfr_pkg::PatternMax));
  assign rlen = sfr_pkg::RlenW'(sfr_pkg::clamp_len(rep_len_q, sfr_pkg::ReplMax));

  sfr_chain u_chain (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .pattern_i (pat_bytes_q),
    .st_o      (st)
  );

  assign slot_free  = !out_valid_q || out_ready_i;
  assign can_prod   = !hold_valid_q || slot_free;
  assign in_ready_o = (state_q == sfr_pkg::StIdle);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ridx_d    = ridx_q;
    last_d    = last_q;
    prod      = 1'b0;
    prod_byte = st.head;
    emit_end  = 1'b0;
    ctl.load  = 1'b0;
    ctl.shift = 1'b0;
    ctl.din   = data_byte_i;
    ctl.count = cnt_q;
    ctl.plen  = plen;

    unique case (state_q)
      sfr_pkg::StIdle: begin
        if (in_valid_i) begin
          ctl.load = 1'b1;
          cnt_d    = cnt_q + sfr_pkg::CntW'(1);
          last_d   = end_of_string_i;
          state_d  = sfr_pkg::StScan;
        end
      end
      sfr_pkg::StScan: begin
        priority if (cnt_q != '0 && !st.is_prefix) begin
          if (can_prod) begin
            prod      = 1'b1;
            ctl.shift = 1'b1;
            cnt_d     = cnt_q - sfr_pkg::CntW'(1);
          end
        end else if (plen != '0 && cnt_q == plen) begin
          cnt_d   = '0;
          ridx_d  = '0;
          state_d = (rlen != '0) ? sfr_pkg::StRepl : sfr_pkg::StDone;
        end else begin
          state_d = last_q ? sfr_pkg::StFlush : sfr_pkg::StDone;
        end
      end
      sfr_pkg::StRepl: begin
        prod_byte = sfr_pkg::byte_at(rep_bytes_q, 32'(ridx_q));
        if (can_prod) begin
          prod   = 1'b1;
          ridx_d = ridx_q + sfr_pkg::RidxW'(1);
          if (sfr_pkg::RlenW'(ridx_q) + sfr_pkg::RlenW'(1) == rlen) begin
            state_d = sfr_pkg::StDone;
          end
        end
      end
      sfr_pkg::StFlush: begin
        if (cnt_q == '0) begin
          state_d = sfr_pkg::StDone;
        end else if (can_prod) begin
          prod      = 1'b1;
          ctl.shift = 1'b1;
          cnt_d     = cnt_q - sfr_pkg::CntW'(1);
        end
      end
      sfr_pkg::StDone: begin
        if (!hold_valid_q && !last_q) begin
          state_d = sfr_pkg::StIdle;
        end else if (slot_free) begin
          emit_end = 1'b1;
          state_d  = sfr_pkg::StIdle;
        end
      end
      default: state_d = sfr_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfr_pkg::StIdle;
      cnt_q   <= '0;
      ridx_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ridx_q  <= ridx_d;
      last_q  <= last_d;
    end
  end

  // one-beat lookahead so the last beat of a string can carry the final flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (prod) begin
      hold_valid_q <= 1'b1;
    end else if (emit_end) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod) begin
      hold_byte_q <= prod_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((prod && hold_valid_q) || emit_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((prod && hold_valid_q) || emit_end) begin
      out_byte_q   <= hold_valid_q ? hold_byte_q : 8'h00;
      out_bvalid_q <= hold_valid_q;
      out_final_q  <= emit_end && last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = out_bvalid_q;
  assign final_item_o = out_final_q;

  `SFR_ASSERT(a_idle_hold_empty, clk_i, rst_ni, in_ready_o |-> !hold_valid_q)
  `SFR_ASSERT(a_idle_cnt_room, clk_i, rst_ni,
              (state_q == sfr_pkg::StIdle) |-> (cnt_q < sfr_pkg::CntW'(sfr_pkg::PatternMax)))
  `SFR_ASSERT(a_bare_mark, clk_i, rst_ni,
              (out_valid_o && !byte_valid_o) |-> (final_item_o && out_byte_o == 8'h00))
  `SFR_ASSERT_ALWAYS(a_reset_quiet, clk_i,
                     !rst_ni |-> (state_q == sfr_pkg::StIdle && !out_valid_q))

endmodule

### tb/tb_stream_find_replace_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_find_replace_core
// Self-checking bench for the streaming find/replace core. A built-in
// rewrite model tracks the pending bytes and the rule registers and queues
// the output beats that each input beat produces. A monitor compares every
// output beat field by field. Directed strings cover pass-through, matches,
// flushes, empty results, clamped lengths and rule changes mid-string.
// Random strings built from pattern fragments then run under three
// sender/receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_stream_find_replace_core;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } out_beat_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic [7:0]                  data_byte_i;
  logic                        end_of_string_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [7:0]                  out_byte_o;
  logic                        byte_valid_o;
  logic                        final_item_o;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [sfr_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [63:0]                 cfg_data_i;

  stream_find_replace_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_string_i(end_of_string_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .final_item_o   (final_item_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // rewrite model state
  logic [7:0]  held[sfr_pkg::PatternMax];
  int unsigned held_cnt;
  logic [63:0] pat_word;
  logic [3:0]  pat_len_reg;
  logic [63:0] rep_word;
  logic [3:0]  rep_len_reg;

  out_beat_t   rewritten_q[$];
  int unsigned mismatch_cnt;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic int unsigned eff_pat_len();
    return (pat_len_reg > sfr_pkg::PatternMax) ? sfr_pkg::PatternMax : pat_len_reg;
  endfunction

  function automatic bit held_fits(int unsigned plen);
    if (held_cnt > plen) return 1'b0;
    for (int i = 0; i < held_cnt; i++)
      if (held[i] != pat_word[8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic rewrite_byte(input logic [7:0] b, input logic eos);
    int unsigned plen;
    int unsigned rlen;
    int unsigned produced;
    out_beat_t   tail;
    plen = eff_pat_len();
    rlen = (rep_len_reg > sfr_pkg::ReplMax) ? sfr_pkg::ReplMax : rep_len_reg;
    produced = 0;
    if (held_cnt < sfr_pkg::PatternMax) begin
      held[held_cnt] = b;
      held_cnt++;
    end
    while (held_cnt > 0 && !held_fits(plen)) begin
      rewritten_q.push_back('{data: held[0], has_byte: 1'b1, last: 1'b0});
      produced++;
      for (int i = 1; i < held_cnt; i++) held[i-1] = held[i];
      held_cnt--;
    end
    if (plen > 0 && held_cnt == plen) begin
      for (int i = 0; i < rlen; i++) begin
        rewritten_q.push_back('{data: rep_word[8*i +: 8], has_byte: 1'b1, last: 1'b0});
        produced++;
      end
      held_cnt = 0;
    end
    if (eos) begin
      for (int i = 0; i < held_cnt; i++) begin
        rewritten_q.push_back('{data: held[i], has_byte: 1'b1, last: 1'b0});
        produced++;
      end
      held_cnt = 0;
      if (produced == 0) rewritten_q.push_back('{data: 8'h00, has_byte: 1'b0, last: 1'b0});
      tail = rewritten_q.pop_back();
      tail.last = 1'b1;
      rewritten_q.push_back(tail);
    end
  endtask

  task automatic flag(input string what, input out_beat_t want, input out_beat_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t %s: exp byte=%02h valid=%0b last=%0b, got byte=%02h valid=%0b last=%0b",
               $realtime, what, want.data, want.has_byte, want.last,
               got.data, got.has_byte, got.last);
  endtask

  always @(posedge clk_i) begin
    out_beat_t want;
    out_beat_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{data: out_byte_o, has_byte: byte_valid_o, last: final_item_o};
      if (rewritten_q.size() == 0) begin
        flag("unexpected beat", '0, got);
      end else begin
        want = rewritten_q.pop_front();
        if (got.data !== want.data || got.has_byte !== want.has_byte ||
            got.last !== want.last)
          flag("mismatch", want, got);
      end
    end
  end

  task automatic write_reg(input logic [sfr_pkg::CfgIdxW-1:0] idx,
                           input logic [63:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sfr_pkg::CfgPatBytes: pat_word    = value;
      sfr_pkg::CfgPatLen:   pat_len_reg = value[3:0];
      sfr_pkg::CfgRepBytes: rep_word    = value;
      sfr_pkg::CfgRepLen:   rep_len_reg = value[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_rule(input logic [63:0] pw, input logic [63:0] pl,
                          input logic [63:0] rw, input logic [63:0] rl);
    write_reg(sfr_pkg::CfgPatBytes, pw);
    write_reg(sfr_pkg::CfgPatLen, pl);
    write_reg(sfr_pkg::CfgRepBytes, rw);
    write_reg(sfr_pkg::CfgRepLen, rl);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    data_byte_i     = b;
    end_of_string_i = eos;
    do @(posedge clk_i); while (!in_ready_o);
    rewrite_byte(b, eos);
  endtask

  // idle the input, let the core empty out, then allow for beats with no output
  task automatic wait_drain();
    int unsigned guard;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    guard = 0;
    while (rewritten_q.size() > 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (16) @(posedge clk_i);
  endtask

  function automatic logic [63:0] len_word(input int unsigned n);
    logic [63:0] w;
    w = {$urandom, $urandom};
    w[3:0] = n[3:0];
    return w;
  endfunction

  task automatic pick_rule();
    logic [63:0] pw;
    int unsigned r;
    int unsigned pl;
    int unsigned rl;
    r  = $urandom_range(99);
    pl = (r < 5) ? 0 : (r < 12) ? $urandom_range(15, 9) : (r < 22) ? 8 : $urandom_range(4, 1);
    for (int i = 0; i < 8; i++)
      pw[8*i +: 8] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(8'h61 + $urandom_range(2));
    rl = ($urandom_range(99) < 15) ? $urandom_range(15, 9) : $urandom_range(8, 0);
    set_rule(pw, len_word(pl), {$urandom, $urandom}, len_word(rl));
  endtask

  task automatic random_string(inout int unsigned sent);
    logic [7:0]  text[$];
    int unsigned want_len;
    int unsigned plen;
    int unsigned cut;
    int unsigned r;
    want_len = $urandom_range(14, 1);
    plen = eff_pat_len();
    while (text.size() < want_len) begin
      r = $urandom_range(99);
      if (r < 35 && plen > 0) begin
        for (int i = 0; i < plen; i++) text.push_back(pat_word[8*i +: 8]);
      end else if (r < 55 && plen > 1) begin
        cut = $urandom_range(plen - 1, 1);
        for (int i = 0; i < cut; i++) text.push_back(pat_word[8*i +: 8]);
      end else if (r < 75) begin
        text.push_back(pat_word[8*$urandom_range(7) +: 8]);
      end else begin
        text.push_back(8'($urandom));
      end
    end
    foreach (text[i]) begin
      send_byte(text[i], i == int'(text.size()) - 1);
      sent++;
      if (i != int'(text.size()) - 1 && $urandom_range(99) < 3) begin
        wait_drain();
        pick_rule();
      end
    end
  endtask

  // reset rule: empty pattern, bytes pass through
  task automatic test_passthrough();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    wait_drain();
  endtask

  task automatic test_basic_match();
    set_rule(64'h6261, 64'd2, 64'h5A5958, 64'd3);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
    // trailing partial match is flushed at the end mark
    send_byte(8'h62, 1'b0);
    send_byte(8'h61, 1'b1);
    wait_drain();
  endtask

  task automatic test_empty_result();
    write_reg(sfr_pkg::CfgRepLen, 64'd0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b1);
    wait_drain();
  endtask

  // lengths above the maximum clamp to eight; all-ones pattern, eight zero-valued bytes out
  task automatic test_clamped_lengths();
    set_rule('1, 64'd15, 64'd0, 64'd12);
    for (int i = 0; i < 8; i++) send_byte(8'hFF, i == 7);
    wait_drain();
  endtask

  task automatic test_rule_change_midstring();
    set_rule(64'h636261, 64'd3, 64'h51, 64'd1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    wait_drain();
    set_rule(64'h7861, 64'd2, 64'h51, 64'd1);
    send_byte(8'h63, 1'b1);
    wait_drain();
  endtask

  task automatic test_random(input int unsigned gap_pct, input int unsigned stall_pct,
                             input int unsigned items);
    int unsigned sent;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 30) begin
        wait_drain();
        pick_rule();
      end
      random_string(sent);
    end
    wait_drain();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    end_of_string_i = 1'b0;
    out_ready_i     = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = sfr_pkg::CfgPatBytes;
    cfg_data_i      = 64'd0;
    pat_word        = 64'd0;
    pat_len_reg     = 4'd0;
    rep_word        = 64'd0;
    rep_len_reg     = 4'd0;
    held_cnt        = 0;
    mismatch_cnt    = 0;
    send_gap_pct    = 23;
    recv_stall_pct  = 80;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_passthrough();
    test_basic_match();
    test_empty_result();
    test_clamped_lengths();
    test_rule_change_midstring();
    test_random(23, 80, 74);
    test_random(80, 23, 73);
    test_random(0, 0, 73);

    while (rewritten_q.size() > 0) flag("missing beat", rewritten_q.pop_front(), '0);
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### stream_find_replace_core.f
+incdir+design
design/sfr_pkg.sv
design/sfr_cell.sv
design/sfr_chain.sv
design/stream_find_replace_core.sv
tb/tb_stream_find_replace_core.sv
